### hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion wrappers; empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// cons must hold in the same cycle as ante
`define ASSERT_IMP(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
		else $error("assertion failed: implication");

// cons must hold in the cycle after ante
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle implication");

`else

`define ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons)

`endif

`endif

### hdl/h264fu_pkg.sv
// ----------------------------------------------------------------------------
// h264fu_pkg
// Types and constants of the RTP H.264 FU-A depacketizer.
// ----------------------------------------------------------------------------
package h264fu_pkg;

	localparam int unsigned BYTE_W  = 8;
	localparam int unsigned PTYPE_W = 7;
	localparam int unsigned CNT_W   = 3;
	localparam int unsigned USER_IN_W  = 1 + PTYPE_W + 1;
	localparam int unsigned USER_OUT_W = 2;

	// configuration register indexes
	localparam logic REG_ACCEPTED_TYPE = 1'b0;
	localparam logic REG_HEADER_BASE   = 1'b1;

	localparam logic [PTYPE_W-1:0] ACCEPTED_TYPE_RST = 7'd96;
	localparam logic [BYTE_W-1:0]  HEADER_BASE_RST   = 8'd96;

	localparam logic [4:0] FU_A_TYPE = 5'd28;

	// byte position inside a packet
	localparam logic [1:0] POS_FIRST  = 2'd0;
	localparam logic [1:0] POS_SECOND = 2'd1;
	localparam logic [1:0] POS_REST   = 2'd2;

	// result counts per request
	localparam logic [CNT_W-1:0] CNT_NONE = 3'd0;
	localparam logic [CNT_W-1:0] CNT_ONE  = 3'd1;
	localparam logic [CNT_W-1:0] CNT_SC   = 3'd5;   // start code + one byte
	localparam logic [CNT_W-1:0] CNT_SC_LAST = 3'd2; // remaining count at byte 01

	localparam logic [BYTE_W-1:0] SC_ZERO = 8'h00;
	localparam logic [BYTE_W-1:0] SC_ONE  = 8'h01;

	// one decoded request waiting to be emitted
	typedef struct packed {
		logic [CNT_W-1:0]  cnt;     // results still to emit
		logic [BYTE_W-1:0] data;    // final byte
		logic              bvalid;  // final result carries data
		logic              fend;    // final result ends a frame
	} job_t;

endpackage

### hdl/h264_rtp_fu_depacketizer.sv
// ----------------------------------------------------------------------------
// h264_rtp_fu_depacketizer
// RTP payload bytes in, H.264 Annex B byte stream out (single NAL and FU-A).
// ----------------------------------------------------------------------------
// Input stream: one RTP payload byte per request, tlast on the last byte of
// a packet, tuser carries packet start, payload type and marker. Output
// stream: one Annex B byte per request, tuser carries byte valid and frame
// end, tlast marks the last result of one input byte.
// An accepted byte is decoded at once into a job register; its results leave
// through the output register. Bytes giving one result sustain one per cycle
// while the output does not stall. A byte that opens a NAL unit (single NAL
// byte 0, FU-A start fragment byte 1) gives start code plus byte, five results,
// and holds the input until its last result moves on. Dropped bytes give a
// flag-only result if they end a frame, else nothing; rejected payload types give nothing.
// Output stall: the output register holds, the job register fills and then
// tready drops; nothing is lost.
// Reset: both registers empty, packet position at byte 0, accepted_type and
// header_base at 96. Config writes go through cfg_we/cfg_index/cfg_data
// and take effect at the next clock.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module h264_rtp_fu_depacketizer (
	input  logic                                clk,
	input  logic                                arst_n,
	// config write port
	input  logic                                cfg_we,
	input  logic                                cfg_index,
	input  logic [h264fu_pkg::BYTE_W-1:0]       cfg_data,
	// input stream
	input  logic                                s_axis_tvalid,
	output logic                                s_axis_tready,
	input  logic [h264fu_pkg::BYTE_W-1:0]       s_axis_tdata,  // payload_byte
	input  logic                                s_axis_tlast,  // last_in_packet
	// first_in_packet[0], payload_type[7:1], marker[8]
	input  logic [h264fu_pkg::USER_IN_W-1:0]    s_axis_tuser,
	// output stream
	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	output logic [h264fu_pkg::BYTE_W-1:0]       m_axis_tdata,  // out_byte
	output logic                                m_axis_tlast,  // last_of_run
	output logic [h264fu_pkg::USER_OUT_W-1:0]   m_axis_tuser   // byte_valid[0], frame_end[1]
);
	import h264fu_pkg::*;

	logic [PTYPE_W-1:0] accepted_type_q;
	logic [BYTE_W-1:0]  header_base_q;
	logic [1:0]         byte_pos_q;
	logic               in_frag_q;

	logic               job_valid_s1;
	job_t               job_s1;

	logic               m_valid_s2;
	logic [BYTE_W-1:0]  m_data_s2;
	logic               m_last_s2;
	logic [USER_OUT_W-1:0] m_user_s2;

	logic               s_accept;
	logic               out_load;
	logic               job_done;

	logic [BYTE_W-1:0]  in_byte;
	logic               in_first;
	logic [PTYPE_W-1:0] in_ptype;
	logic               in_mark;
	logic [1:0]         pos;
	logic               frag;
	logic               type_ok;
	logic               frame_end;
	logic [BYTE_W-1:0]  rebuilt_hdr;
	job_t               job_new;
	logic [1:0]         pos_next;

	assign in_byte  = s_axis_tdata;
	assign in_first = s_axis_tuser[0];
	assign in_ptype = s_axis_tuser[PTYPE_W:1];
	assign in_mark  = s_axis_tuser[PTYPE_W+1];

	assign out_load      = !m_valid_s2 || m_axis_tready;
	assign job_done      = job_valid_s1 && out_load && (job_s1.cnt == CNT_ONE);
	assign s_axis_tready = !job_valid_s1 || job_done;
	assign s_accept      = s_axis_tvalid && s_axis_tready;

	// ---- decode of the incoming byte ----
	always_comb begin
		pos         = in_first ? POS_FIRST : byte_pos_q;
		frag        = (pos == POS_FIRST) ? (in_byte[4:0] == FU_A_TYPE) : in_frag_q;
		type_ok     = (in_ptype == accepted_type_q);
		frame_end   = s_axis_tlast && in_mark;
		rebuilt_hdr = {3'b000, in_byte[4:0]} + header_base_q;

		job_new.cnt    = CNT_NONE;
		job_new.data   = in_byte;
		job_new.bvalid = 1'b1;
		job_new.fend   = frame_end;

		if (!frag) begin
			job_new.cnt = (pos == POS_FIRST) ? CNT_SC : CNT_ONE;
		end else if (pos == POS_SECOND) begin
			if (in_byte[7]) begin
				job_new.cnt  = CNT_SC;
				job_new.data = rebuilt_hdr;
			end
		end else if (pos != POS_FIRST) begin
			job_new.cnt = CNT_ONE;
		end

		// flag-only result for a dropped byte that closes a frame
		if (frame_end && (job_new.cnt == CNT_NONE)) begin
			job_new.cnt    = CNT_ONE;
			job_new.data   = SC_ZERO;
			job_new.bvalid = 1'b0;
		end

		if (!type_ok) begin
			job_new.cnt = CNT_NONE;
		end

		if (s_axis_tlast) begin
			pos_next = POS_FIRST;
		end else if (pos == POS_FIRST) begin
			pos_next = POS_SECOND;
		end else begin
			pos_next = POS_REST;
		end
	end

	// ---- configuration registers ----
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			accepted_type_q <= ACCEPTED_TYPE_RST;
			header_base_q   <= HEADER_BASE_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_ACCEPTED_TYPE: accepted_type_q <= cfg_data[PTYPE_W-1:0];
				REG_HEADER_BASE:   header_base_q   <= cfg_data;
				default:           ;
			endcase
		end
	end

	// ---- packet position tracking ----
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_pos_q <= POS_FIRST;
			in_frag_q  <= 1'b0;
		end else if (s_accept) begin
			byte_pos_q <= pos_next;
			in_frag_q  <= frag;
		end
	end

	// ---- job register ----
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			job_valid_s1 <= 1'b0;
			job_s1       <= '0;
		end else if (s_accept) begin
			job_valid_s1 <= (job_new.cnt != CNT_NONE);
			job_s1       <= job_new;
		end else if (job_valid_s1 && out_load) begin
			job_valid_s1 <= (job_s1.cnt != CNT_ONE);
			job_s1.cnt   <= job_s1.cnt - CNT_ONE;
		end
	end

	// ---- output register ----
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_s2 <= 1'b0;
		end else if (out_load) begin
			m_valid_s2 <= job_valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load && job_valid_s1) begin
			if (job_s1.cnt == CNT_ONE) begin
				m_data_s2 <= job_s1.bvalid ? job_s1.data : SC_ZERO;
				m_user_s2 <= {job_s1.fend, job_s1.bvalid};
				m_last_s2 <= 1'b1;
			end else begin
				m_data_s2 <= (job_s1.cnt == CNT_SC_LAST) ? SC_ONE : SC_ZERO;
				m_user_s2 <= 2'b01;
				m_last_s2 <= 1'b0;
			end
		end
	end

	assign m_axis_tvalid = m_valid_s2;
	assign m_axis_tdata  = m_data_s2;
	assign m_axis_tlast  = m_last_s2;
	assign m_axis_tuser  = m_user_s2;

	// ---- assertions ----
	`ASSERT_IMP(a_stall_only_busy, clk, arst_n, !s_axis_tready, job_valid_s1)
	`ASSERT_IMP(a_job_cnt_range, clk, arst_n, job_valid_s1,
		(job_s1.cnt != CNT_NONE) && (job_s1.cnt <= CNT_SC))
	`ASSERT_IMP(a_pos_range, clk, arst_n, 1'b1, byte_pos_q != 2'd3)
	`ASSERT_NEXT(a_job_kept, clk, arst_n,
		job_valid_s1 && out_load && (job_s1.cnt != CNT_ONE), job_valid_s1)
	`ASSERT_IMP(a_flag_only_ends, clk, arst_n, m_valid_s2 && !m_user_s2[0],
		m_last_s2 && m_user_s2[1])

endmodule
